// ===== rtl/core/ket_pkg.sv =====
// Package for the keyed entry table: default sizes, request/result structs,
// operation and status codes, and sequencer states. No dependencies.
package ket_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] entry_key;
        logic [FIELD_W-1:0] entry_payload;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  read_payload;
        logic [COUNT_W-1:0]  used_count;
        logic [COUNT_W-1:0]  free_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/core/ket_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ket_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/keyed_entry_table_unit.sv =====
// Keyed entry table top level: sequencer that scans the entry RAM one slot a
// cycle, then updates at most one slot. Depends on ket_pkg and ket_ram.
//
//  channel   handshake            payload
//  -------   -------------------  --------------------------------
//  request   start & !busy        request (ket_pkg::req_t)
//  result    done, one cycle      result  (ket_pkg::rsp_t)
//
// A request reads the RAM once per slot, checks each read word as it returns,
// then decides and writes back; done and the result are registered from that
// last step, and a new request is taken only once the unit is idle again.
// After reset the RAM is swept to zero slot by slot, with busy high.
// The result is shown for one cycle; the receiver cannot stall it.
module keyed_entry_table_unit #(
    parameter int CAPACITY     = ket_pkg::CAPACITY_DEF,
    parameter int KEY_BITS     = ket_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = ket_pkg::PAYLOAD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ket_pkg::req_t request,
    output logic          done,
    output ket_pkg::rsp_t result
);

    localparam int KW = (KEY_BITS < ket_pkg::FIELD_W) ? KEY_BITS : ket_pkg::FIELD_W;
    localparam int PW = (PAYLOAD_BITS < ket_pkg::FIELD_W) ? PAYLOAD_BITS : ket_pkg::FIELD_W;
    localparam int EW = 1 + KW + PW;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    ket_pkg::state_t state_reg, state_next;

    ket_pkg::req_t req_reg, req_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [PW-1:0] hit_pay_reg, hit_pay_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [CW-1:0] used_reg, used_next;
    logic          done_reg, done_next;
    ket_pkg::rsp_t rsp_reg, rsp_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic          rd_valid;
    logic [KW-1:0] rd_key;
    logic [PW-1:0] rd_pay;
    logic          accept;
    logic          last_check;

    ket_ram #(
        .WIDTH(EW),
        .DEPTH(CAPACITY)
    ) u_entries (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // entry word: {valid, key, payload}
    assign rd_valid = ram_rdata[EW-1];
    assign rd_key   = ram_rdata[KW+PW-1:PW];
    assign rd_pay   = ram_rdata[PW-1:0];

    assign busy       = (state_reg != ket_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign last_check = chk_vld_reg && (chk_idx_reg == LAST_IDX);
    assign done       = done_reg;
    assign result     = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ket_pkg::ST_CLEAR:
            begin
                if (scan_idx_reg[IW-1:0] == LAST_IDX)
                begin
                    state_next = ket_pkg::ST_IDLE;
                end
            end
            ket_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ket_pkg::ST_SCAN;
                end
            end
            ket_pkg::ST_SCAN:
            begin
                if (last_check)
                begin
                    state_next = ket_pkg::ST_FINISH;
                end
            end
            ket_pkg::ST_FINISH:
            begin
                state_next = ket_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ket_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next      = req_reg;
        scan_idx_next = scan_idx_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_pay_next  = hit_pay_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        used_next     = used_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        ram_we        = 1'b0;
        ram_waddr     = scan_idx_reg[IW-1:0];
        ram_wdata     = '0;
        ram_raddr     = scan_idx_reg[IW-1:0];

        unique case (state_reg)
            ket_pkg::ST_CLEAR:
            begin
                ram_we        = 1'b1;
                scan_idx_next = scan_idx_reg + CW'(1);
            end
            ket_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next      = request;
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                end
            end
            ket_pkg::ST_SCAN:
            begin
                if (scan_idx_reg < CW'(CAPACITY))
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_idx_reg[IW-1:0];
                end
                // read data comes back in the cycle after its address
                if (chk_vld_reg)
                begin
                    if (rd_valid && (rd_key == req_reg.entry_key[KW-1:0]) && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = chk_idx_reg;
                        hit_pay_next = rd_pay;
                    end
                    if (!rd_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                end
            end
            ket_pkg::ST_FINISH:
            begin
                done_next             = 1'b1;
                rsp_next.status       = ket_pkg::STATUS_OK;
                rsp_next.read_payload = '0;
                case (req_reg.kind)
                    ket_pkg::KIND_ADD:
                    begin
                        ram_wdata = {1'b1, req_reg.entry_key[KW-1:0],
                                     req_reg.entry_payload[PW-1:0]};
                        if (hit_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_idx_reg;
                        end
                        else if (free_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = free_idx_reg;
                            used_next = used_reg + CW'(1);
                        end
                        else
                        begin
                            rsp_next.status = ket_pkg::STATUS_FULL;
                        end
                    end
                    ket_pkg::KIND_GET:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.read_payload = ket_pkg::FIELD_W'(hit_pay_reg);
                        end
                        else
                        begin
                            rsp_next.status = ket_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    ket_pkg::KIND_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_idx_reg;
                            used_next = used_reg - CW'(1);
                        end
                        else
                        begin
                            rsp_next.status = ket_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ket_pkg::STATUS_OK;
                    end
                endcase
                rsp_next.used_count = ket_pkg::COUNT_W'(used_next);
                rsp_next.free_count = ket_pkg::COUNT_W'(CW'(CAPACITY) - used_next);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ket_pkg::ST_CLEAR;
            scan_idx_reg <= '0;
            chk_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            used_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            chk_vld_reg  <= chk_vld_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            used_reg     <= used_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_pay_reg  <= hit_pay_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for keyed_entry_table_unit: directed then random add/get/remove
// and unused-code requests, each result checked against a local model of the slot
// table. Depends on ket_pkg and the keyed_entry_table_unit RTL.
module tb_top;
    import ket_pkg::*;

    localparam int                SLOTS       = CAPACITY_DEF;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int                RAND_ITEMS  = 700;
    localparam int                PHASE_LEN   = 175;
    localparam int                POOL_SIZE   = 24;

    typedef struct {
        req_t        req;
        int unsigned gap_pct;
        bit          drain;
    } pending_req_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    logic req_taken = 1'b0;
    int   err_count = 0;

    pending_req_t request_backlog[$];
    rsp_t         expected_results[$];

    // local copy of the slot table
    bit                 shadow_valid[SLOTS];
    logic [FIELD_W-1:0] shadow_key[SLOTS];
    logic [FIELD_W-1:0] shadow_payload[SLOTS];
    int                 shadow_used = 0;

    keyed_entry_table_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Applies one request to the shadow table and returns the result it should give.
    function automatic rsp_t apply_table_op(input req_t r);
        rsp_t res;
        int   hit;
        int   free_slot;
        hit       = -1;
        free_slot = -1;
        res       = '0;
        res.status = STATUS_OK;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == r.entry_key)
                hit = i;
            if (free_slot < 0 && !shadow_valid[i])
                free_slot = i;
        end
        case (r.kind)
            KIND_ADD:
            begin
                if (hit >= 0)
                    shadow_payload[hit] = r.entry_payload;
                else if (free_slot >= 0)
                begin
                    shadow_valid[free_slot]   = 1'b1;
                    shadow_key[free_slot]     = r.entry_key;
                    shadow_payload[free_slot] = r.entry_payload;
                    shadow_used++;
                end
                else
                    res.status = STATUS_FULL;
            end
            KIND_GET:
            begin
                if (hit >= 0)
                    res.read_payload = shadow_payload[hit];
                else
                    res.status = STATUS_NOT_FOUND;
            end
            KIND_REMOVE:
            begin
                if (hit >= 0)
                begin
                    shadow_valid[hit] = 1'b0;
                    shadow_used--;
                end
                else
                    res.status = STATUS_NOT_FOUND;
            end
            default: ;  // unused code: no change
        endcase
        res.used_count = COUNT_W'(shadow_used);
        res.free_count = COUNT_W'(SLOTS - shadow_used);
        return res;
    endfunction

    task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [FIELD_W-1:0] key,
                                 input logic [FIELD_W-1:0] payload, input int unsigned gap_pct,
                                 input bit drain);
        pending_req_t p;
        p.req.kind          = kind;
        p.req.entry_key     = key;
        p.req.entry_payload = payload;
        p.gap_pct           = gap_pct;
        p.drain             = drain;
        request_backlog.push_back(p);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Driver: presents the backlog head at the falling edge, holds it until accepted.
    always @(negedge clk)
    begin : drive_requests
        logic presenting;
        presenting = start;
        if (!rst_n)
            presenting = 1'b0;
        else
        begin
            if (req_taken)
            begin
                request_backlog.delete(0);
                presenting = 1'b0;
            end
            if (!presenting && request_backlog.size() != 0)
            begin
                // drain marker: hold off until every outstanding result is back
                if (!(request_backlog[0].drain && expected_results.size() != 0)
                    && $urandom_range(99) >= request_backlog[0].gap_pct)
                    presenting = 1'b1;
            end
        end
        start <= presenting;
        if (presenting)
            request <= request_backlog[0].req;
    end

    // Monitor: checks results, then records the request accepted at this edge.
    always @(posedge clk)
    begin : watch_results
        rsp_t want;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        err_count++;
                    end
                    if (result.read_payload !== want.read_payload)
                    begin
                        $error("read_payload: expected %h, got %h",
                               want.read_payload, result.read_payload);
                        err_count++;
                    end
                    if (result.used_count !== want.used_count)
                    begin
                        $error("used_count: expected %0d, got %0d",
                               want.used_count, result.used_count);
                        err_count++;
                    end
                    if (result.free_count !== want.free_count)
                    begin
                        $error("free_count: expected %0d, got %0d",
                               want.free_count, result.free_count);
                        err_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_table_op(request));
            req_taken <= start && !busy;
        end
    end

    initial
    begin : stimulus
        logic [FIELD_W-1:0] key_pool[POOL_SIZE];
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] payload;
        logic [KIND_W-1:0]  kind;
        int unsigned        gap_pct;
        int unsigned        add_bias;
        int unsigned        roll;
        bit                 drain;

        // directed: empty-table misses, unused code, key/payload extremes, update, remove
        queue_request(KIND_GET,    32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0);
        queue_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        queue_request(KIND_UNUSED, $urandom(),    $urandom(),    0, 1'b0);
        queue_request(KIND_ADD,    32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        queue_request(KIND_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
        queue_request(KIND_GET,    32'h0000_0000, $urandom(),    0, 1'b0);
        queue_request(KIND_GET,    32'hFFFF_FFFF, $urandom(),    0, 1'b0);
        queue_request(KIND_ADD,    32'h0000_0000, 32'hA5A5_5A5A, 0, 1'b0);
        queue_request(KIND_GET,    32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        queue_request(KIND_GET,    32'h8000_0000, 32'h0000_0000, 0, 1'b0);
        queue_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
        queue_request(KIND_GET,    32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        queue_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        queue_request(KIND_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0);
        queue_request(KIND_ADD,    32'hFFFF_FFFF, 32'h1234_5678, 0, 1'b0);
        queue_request(KIND_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);

        // random: small key pool so the table fills and empties; add-heavy and
        // remove-heavy stretches alternate
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                for (int k = 0; k < POOL_SIZE; k++)
                    key_pool[k] = $urandom();
                key_pool[0] = 32'h0000_0000;
                key_pool[1] = 32'hFFFF_FFFF;
            end
            case (n / PHASE_LEN)
                1:       gap_pct = 55;
                2:       gap_pct = 17;
                default: gap_pct = 0;
            endcase
            add_bias = ((n / 40) % 2 == 0) ? 65 : 25;
            key      = key_pool[$urandom_range(POOL_SIZE - 1)];
            roll     = $urandom_range(99);
            if (roll < 8)
            begin
                // noise: any code, near-miss or wild key
                kind = KIND_W'($urandom_range(3));
                if ($urandom_range(1) == 0)
                    key = key ^ (32'h1 << $urandom_range(FIELD_W - 1));
                else
                    key = $urandom();
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < add_bias)
                    kind = KIND_ADD;
                else if (roll < add_bias + (100 - add_bias) / 2)
                    kind = KIND_GET;
                else
                    kind = KIND_REMOVE;
            end
            case ($urandom_range(15))
                0:       payload = 32'h0000_0000;
                1:       payload = 32'hFFFF_FFFF;
                default: payload = $urandom();
            endcase
            drain = (n % PHASE_LEN == 0) || ($urandom_range(99) == 0);
            queue_request(kind, key, payload, gap_pct, drain);
        end

        while (request_backlog.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== keyed_entry_table_unit.f =====
rtl/core/ket_pkg.sv
rtl/core/ket_ram.sv
rtl/core/keyed_entry_table_unit.sv
test/tb_top.sv
